### rtl/core/ffia_pkg.sv
// Shared types and constants for the first-free identifier allocator.
// Holds the request kinds, the result status codes, the sequencer state type
// and the bitmap word geometry. Depends on nothing.
package ffia_pkg;

    // Field widths of the request and result ports.
    localparam int KIND_W = 2;
    localparam int ID_W   = 9;
    localparam int STAT_W = 2;

    // Default number of identifiers, numbered from one.
    localparam int NUM_IDS_DEF = 256;

    // The used-bit map is held as words of WORD_W bits.
    localparam int WORD_SHIFT = 5;
    localparam int WORD_W     = 1 << WORD_SHIFT;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RMW,
        FSM_SCAN,
        FSM_RESP
    } fsm_state_t;

endpackage

### rtl/core/ffia_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the allocator's used-bit map. Depends on nothing.
module ffia_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/first_free_id_allocator_unit.sv
// Top level of the first-free identifier allocator.
// Depends on ffia_pkg for codes and geometry and on ffia_ram for the used-bit map.
// A small sequencer drives one word read, test and write path over the map.
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  ------------------------------
//  request   in         s_valid / s_ready   s_kind[1:0], s_ident[8:0]
//  result    out        m_valid / m_ready   m_granted[8:0], m_status[1:0]
//
// Steps: clear_all and rejected identifiers go straight to the result state once the
// request is taken, mark_used and release first pass through one read-modify-write of
// a map word, and allocate scans the map words of 32 bits from the lowest until one
// holds a free identifier. A full map scans as far as a hit in the last word, so the
// scan reads at most NUM_IDS/32 rounded up words; the single map RAM port pair sets
// this order of steps.
// Reset: the sequencer returns to idle and every per-word valid flag clears, so the
// whole map reads as free at once with no clearing pass.
// Stalls: one request is in flight at a time; s_ready is low from acceptance until
// the result has been taken on the result channel.
module first_free_id_allocator_unit
    import ffia_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [ID_W-1:0]   s_ident,
    // Result channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ID_W-1:0]   m_granted,
    output logic [STAT_W-1:0] m_status
);

    // Map geometry derived from the identifier count.
    localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(NUM_IDS + 1);
    // Wide enough to hold both the identifier port and NUM_IDS itself.
    localparam int CMP_W     = (ID_W > CNT_W) ? ID_W : CNT_W;
    // Width of an identifier built from a word index and a bit position.
    localparam int GID_W     = WADDR_W + WORD_SHIFT + 1;
    // Number of real identifiers held in the last map word.
    localparam int TAIL      = NUM_IDS - (NUM_WORDS - 1) * WORD_W;
    // Bits of the last word beyond NUM_IDS are treated as permanently used.
    localparam logic [WORD_W-1:0] TAIL_MASK = (TAIL == WORD_W) ? '0 :
        ~((WORD_W'(1) << TAIL) - WORD_W'(1));
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

    // Sequencer and request registers.
    fsm_state_t             state_reg, state_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [WADDR_W-1:0]     addr_reg, addr_next;
    logic [WORD_SHIFT-1:0]  bit_reg, bit_next;
    logic [NUM_WORDS-1:0]   wvalid_reg, wvalid_next;
    logic [ID_W-1:0]        granted_reg, granted_next;
    logic [STAT_W-1:0]      status_reg, status_next;

    // Map RAM ports.
    logic                   ram_we;
    logic [WADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [WADDR_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    // Decode of the incoming request.
    logic                   s_fire;
    logic                   id_ok;
    logic [CMP_W-1:0]       ident_m1;
    logic [WADDR_W-1:0]     ident_word;
    logic [WORD_SHIFT-1:0]  ident_bit;

    // Word under test.
    logic [WORD_W-1:0]      rd_word;
    logic [WORD_W-1:0]      scan_view;
    logic [WORD_W-1:0]      bit_onehot;
    logic                   is_last;
    logic                   free_found;
    logic [WORD_SHIFT-1:0]  free_bit;
    logic [GID_W-1:0]       free_gid;

    ffia_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (NUM_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == FSM_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (state_reg == FSM_RESP);
    assign m_granted = granted_reg;
    assign m_status  = status_reg;

    // Identifier zero and anything above NUM_IDS are rejected. Identifier n lives
    // in bit (n-1) mod 32 of word (n-1)/32.
    assign id_ok      = (s_ident != '0) && (CMP_W'(s_ident) <= CMP_W'(NUM_IDS));
    assign ident_m1   = CMP_W'(s_ident) - CMP_W'(1);
    assign ident_word = WADDR_W'(ident_m1 >> WORD_SHIFT);
    assign ident_bit  = ident_m1[WORD_SHIFT-1:0];

    // A word whose valid flag is clear has not been written since the last reset
    // or clear_all, so it reads as all free regardless of what the RAM holds.
    assign rd_word    = wvalid_reg[addr_reg] ? ram_rdata : '0;
    assign is_last    = (addr_reg == LAST_WORD);
    assign scan_view  = rd_word | (is_last ? TAIL_MASK : '0);
    assign bit_onehot = WORD_W'(1) << bit_reg;
    assign free_found = ~&scan_view;
    assign free_gid   = GID_W'({addr_reg, free_bit}) + GID_W'(1);

    // Lowest clear bit of the word under test.
    always_comb begin
        free_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!scan_view[i]) begin
                free_bit = WORD_SHIFT'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    case (s_kind)
                        KIND_ALLOC: begin
                            state_next = FSM_SCAN;
                        end
                        KIND_MARK, KIND_RELEASE: begin
                            state_next = id_ok ? FSM_RMW : FSM_RESP;
                        end
                        default: begin
                            state_next = FSM_RESP;
                        end
                    endcase
                end
            end
            FSM_RMW: begin
                state_next = FSM_RESP;
            end
            FSM_SCAN: begin
                if (free_found || is_last) begin
                    state_next = FSM_RESP;
                end
            end
            FSM_RESP: begin
                if (m_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result values.
    always_comb begin
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        bit_next     = bit_reg;
        wvalid_next  = wvalid_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = rd_word;
        ram_re       = 1'b0;
        ram_raddr    = addr_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    kind_next    = s_kind;
                    granted_next = '0;
                    status_next  = STAT_OK;
                    case (s_kind)
                        KIND_ALLOC: begin
                            // Start the scan at the lowest word.
                            addr_next = '0;
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                        end
                        KIND_MARK, KIND_RELEASE: begin
                            if (id_ok) begin
                                addr_next = ident_word;
                                bit_next  = ident_bit;
                                ram_re    = 1'b1;
                                ram_raddr = ident_word;
                                if (s_kind == KIND_MARK) begin
                                    granted_next = s_ident;
                                end
                            end else begin
                                status_next = STAT_INVALID;
                            end
                        end
                        default: begin
                            // Clearing the valid flags frees the whole map at once.
                            wvalid_next = '0;
                        end
                    endcase
                end
            end
            FSM_RMW: begin
                ram_we                = 1'b1;
                ram_wdata             = (kind_reg == KIND_MARK) ? (rd_word | bit_onehot)
                                                                : (rd_word & ~bit_onehot);
                wvalid_next[addr_reg] = 1'b1;
            end
            FSM_SCAN: begin
                if (free_found) begin
                    ram_we                = 1'b1;
                    ram_wdata             = rd_word | (WORD_W'(1) << free_bit);
                    wvalid_next[addr_reg] = 1'b1;
                    granted_next          = ID_W'(free_gid);
                    status_next           = STAT_OK;
                end else if (is_last) begin
                    granted_next = '0;
                    status_next  = STAT_FULL;
                end else begin
                    addr_next = addr_reg + WADDR_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg + WADDR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control state is reset; the request and result payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FSM_IDLE;
            wvalid_reg <= '0;
        end else begin
            state_reg  <= state_next;
            wvalid_reg <= wvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        addr_reg    <= addr_next;
        bit_reg     <= bit_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

`ifndef ASSERT_OFF
    // The block never takes a new request while a result is waiting.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // Once a request is taken the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("ready stayed high after a request was accepted");

    // A full result never carries an identifier.
    a_full_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_FULL)) |-> (m_granted == '0))
        else $error("full status returned with a non-zero identifier");

    // The map is only written from the read-modify-write or scan steps.
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == FSM_RMW) || (state_reg == FSM_SCAN)))
        else $error("map written outside an update step");

    // Map reads and writes never coincide.
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("map read and write issued in the same cycle");
`endif

endmodule

### tb/first_free_id_allocator_unit_test.sv
// Self-checking testbench for the first-free identifier allocator top level.
// Depends on ffia_pkg for field widths, request kinds and status codes, and
// on first_free_id_allocator_unit as the block under test.
module first_free_id_allocator_unit_test;
    import ffia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default size, so the predictor uses the same figure.
    localparam int NUM_IDS     = NUM_IDS_DEF;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int MAX_REPORTS = 10;

    // One result as the block presents it on the result channel.
    typedef struct packed {
        logic [ID_W-1:0]   granted;
        logic [STAT_W-1:0] status;
    } alloc_result_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind;
    logic [ID_W-1:0]   s_ident;
    logic              m_valid;
    logic              m_ready;
    logic [ID_W-1:0]   m_granted;
    logic [STAT_W-1:0] m_status;

    // The testbench's own copy of the used-bit map, indexed by identifier.
    logic [NUM_IDS:1] id_used;

    // Results that have been worked out for accepted requests but not yet seen.
    alloc_result_t awaited_results[$];

    // When clear, neither side inserts idle bursts.
    bit idle_enable = 1'b1;

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned full_results;
    int unsigned invalid_results;
    int unsigned kind_count[4];

    first_free_id_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_ident   (s_ident),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_granted (m_granted),
        .m_status  (m_status)
    );

    // 12 ns clock: six nanoseconds low, six high.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog. The slowest correct run stays under a quarter of this limit, even with
    // every request paying the longest idle gap, the longest scan of the map and the
    // longest stall on the result side.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** first_free_id_allocator_unit: FAILED **");
            $finish;
        end
    end

    // Applies one request to the local map and returns the result that the block
    // must give for it. Every request yields exactly one result.
    function automatic alloc_result_t apply_to_id_map(input logic [KIND_W-1:0] kind,
                                                      input logic [ID_W-1:0] ident);
        alloc_result_t res;
        bit            in_range;
        bit            found;
        res.granted = '0;
        res.status  = STAT_OK;
        in_range    = (ident >= 1) && (ident <= NUM_IDS);
        found       = 1'b0;
        case (kind)
            KIND_ALLOC: begin
                // The lowest free identifier wins; a full map leaves everything as is.
                for (int i = 1; i <= NUM_IDS; i++) begin
                    if (!found && !id_used[i]) begin
                        id_used[i]  = 1'b1;
                        res.granted = ID_W'(i);
                        found       = 1'b1;
                    end
                end
                if (!found) begin
                    res.status = STAT_FULL;
                end
            end
            KIND_MARK: begin
                // Marking a used identifier again is harmless and still echoes it.
                if (in_range) begin
                    id_used[ident] = 1'b1;
                    res.granted    = ident;
                end else begin
                    res.status = STAT_INVALID;
                end
            end
            KIND_RELEASE: begin
                // Releasing a free identifier is accepted silently.
                if (in_range) begin
                    id_used[ident] = 1'b0;
                end else begin
                    res.status = STAT_INVALID;
                end
            end
            default: begin
                id_used = '0;
            end
        endcase
        return res;
    endfunction

    // Picks an identifier that is in use, starting from a random point, so that
    // releases mostly hit live entries. Falls back to any valid identifier.
    function automatic logic [ID_W-1:0] pick_used_ident();
        int start;
        int idx;
        start = $urandom_range(1, NUM_IDS);
        for (int n = 0; n < NUM_IDS; n++) begin
            idx = ((start - 1 + n) % NUM_IDS) + 1;
            if (id_used[idx]) begin
                return ID_W'(idx);
            end
        end
        return ID_W'(start);
    endfunction

    // Identifier zero or one above the map, up to the largest value the port holds.
    function automatic logic [ID_W-1:0] pick_bad_ident();
        if ($urandom_range(0, 2) == 0) begin
            return '0;
        end
        return ID_W'($urandom_range(NUM_IDS + 1, (1 << ID_W) - 1));
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Sends one request. Inputs change at the falling edge; acceptance is taken at
    // the rising edge where valid and ready are both high, and the expected result
    // is worked out at that moment. Valid is left high on return, so that the next
    // request follows without a gap unless an idle burst is drawn.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] ident);
        int gap;
        @(negedge aclk);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap     = $urandom_range(1, 16);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_kind  = kind;
        s_ident = ident;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        awaited_results.push_back(apply_to_id_map(kind, ident));
        kind_count[kind]++;
    endtask

    // Holds the request side idle until every outstanding result has come back.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Result side: ready is dropped in random bursts while idling is enabled.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if (idle_enable && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 16);
                end
            end
        end
    end

    // Each result taken on the result channel is compared with the oldest expectation.
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("result granted=%0d status=%0d with none expected",
                                        m_granted, m_status));
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (want.status == STAT_FULL) begin
                    full_results++;
                end
                if (want.status == STAT_INVALID) begin
                    invalid_results++;
                end
                if (m_granted !== want.granted || m_status !== want.status) begin
                    note_mismatch($sformatf("granted %0d/%0d status %0d/%0d (expected/actual)",
                                            want.granted, m_granted, want.status, m_status));
                end
            end
        end
    end

    // Hand-picked requests: each kind, identifiers at both ends of the port range,
    // repeated marks, releases of free entries and ignored identifier fields.
    task automatic test_directed();
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '1);                      // identifier field is ignored
        send_request(KIND_MARK, '0);                       // identifier zero is rejected
        send_request(KIND_MARK, ID_W'(NUM_IDS));           // top of the map
        send_request(KIND_MARK, ID_W'(NUM_IDS + 1));       // just past the map
        send_request(KIND_MARK, '1);
        send_request(KIND_RELEASE, '0);
        send_request(KIND_RELEASE, '1);
        send_request(KIND_RELEASE, ID_W'(NUM_IDS + 1));
        send_request(KIND_MARK, ID_W'(2));                 // already in use
        send_request(KIND_RELEASE, ID_W'(100));            // already free
        send_request(KIND_RELEASE, ID_W'(1));
        send_request(KIND_ALLOC, ID_W'(9'h0AA));           // must reuse identifier one
        send_request(KIND_MARK, ID_W'(3));
        send_request(KIND_ALLOC, ID_W'(9'h155));           // skips over the marked one
        send_request(KIND_MARK, ID_W'(33));                // second map word
        send_request(KIND_RELEASE, ID_W'(33));
        send_request(KIND_MARK, ID_W'(9'h0AA));
        send_request(KIND_RELEASE, ID_W'(9'h155));
        send_request(KIND_CLEAR, ID_W'(9'h155));
        send_request(KIND_ALLOC, '0);
        send_request(KIND_RELEASE, ID_W'(NUM_IDS));        // free after the clear
        send_request(KIND_CLEAR, '0);
    endtask

    // Fills the whole map with a mix of allocations and marks, then checks the full
    // case, the reuse of a single released hole and the clear of a full map.
    task automatic test_exhaustion();
        logic [ID_W-1:0] hole;
        while (!(&id_used)) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(KIND_MARK, ID_W'($urandom_range(1, NUM_IDS)));
            end else begin
                send_request(KIND_ALLOC, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
            end
        end
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '1);
        send_request(KIND_MARK, pick_used_ident());
        send_request(KIND_RELEASE, pick_bad_ident());
        hole = pick_used_ident();
        send_request(KIND_RELEASE, hole);
        send_request(KIND_ALLOC, '0);                      // takes the hole back
        send_request(KIND_ALLOC, '0);                      // full again
        send_request(KIND_CLEAR, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
    endtask

    // Well-formed traffic with random content. alloc_pct sets how often a request
    // allocates; half of the rest are releases of live entries, so a high figure
    // drives the map towards full and a low one drains it.
    task automatic run_traffic(input int count, input int alloc_pct);
        int pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_request(KIND_ALLOC, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_request(KIND_RELEASE, pick_used_ident());
                end else if (pick < 70) begin
                    send_request(KIND_MARK, ID_W'($urandom_range(1, NUM_IDS)));
                end else if (pick < 82) begin
                    send_request(KIND_RELEASE, ID_W'($urandom_range(1, NUM_IDS)));
                end else if (pick < 96) begin
                    send_request($urandom_range(0, 1) ? KIND_MARK : KIND_RELEASE,
                                 pick_bad_ident());
                end else if (pick < 99) begin
                    // Noise: an allocate carrying an arbitrary identifier.
                    send_request(KIND_ALLOC, pick_bad_ident());
                end else begin
                    send_request(KIND_CLEAR, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
                end
            end
        end
    endtask

    // Alternating fill and drain phases, some with idling on both sides and some
    // without, so that the map passes through full and near-empty states repeatedly.
    task automatic test_random_traffic();
        idle_enable = 1'b1;
        run_traffic(200, 80);
        run_traffic(250, 25);
        idle_enable = 1'b0;
        run_traffic(150, 85);
        idle_enable = 1'b1;
        run_traffic(200, 50);
        run_traffic(200, 90);
    endtask

    // The sender waits for every outstanding result before going on.
    task automatic test_drain_pause();
        wait_for_drain();
        run_traffic(40, 60);
        wait_for_drain();
    endtask

    // Back-to-back requests with the result side always ready.
    task automatic test_full_rate();
        idle_enable = 1'b0;
        run_traffic(200, 55);
        run_traffic(100, 85);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind  = KIND_ALLOC;
        s_ident = '0;
        id_used = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_exhaustion();
        test_random_traffic();
        test_drain_pause();
        test_full_rate();

        wait_for_drain();
        repeat (32) @(posedge aclk);

        $display("Sent %0d requests: %0d allocate, %0d mark, %0d release, %0d clear.",
                 kind_count[KIND_ALLOC] + kind_count[KIND_MARK] + kind_count[KIND_RELEASE]
                 + kind_count[KIND_CLEAR], kind_count[KIND_ALLOC], kind_count[KIND_MARK],
                 kind_count[KIND_RELEASE], kind_count[KIND_CLEAR]);
        $display("Checked %0d results, %0d on a full map and %0d for bad identifiers.",
                 results_checked, full_results, invalid_results);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("** first_free_id_allocator_unit: PASSED **");
        end else begin
            $display("** first_free_id_allocator_unit: FAILED **");
        end
        $finish;
    end

endmodule
